@@ rtl/core/mlfq_thread_scheduler_defines.svh @@
// Assertion macros for the MLFQ thread scheduler checker.
// Depends on a clk and an active-high rst in the scope of each use.
`ifndef MLFQ_THREAD_SCHEDULER_DEFINES_SVH
`define MLFQ_THREAD_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MLFQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/mlfq_pkg.sv @@
// Shared types and constants of the MLFQ thread scheduler.
// No dependencies.
package mlfq_pkg;

  localparam int LEVELS     = 4;
  localparam int THREADS    = 32;
  localparam int LVL_W      = $clog2(LEVELS);
  localparam int TID_W      = $clog2(THREADS);
  localparam int CNT_W      = TID_W + 1;
  localparam int SLOT_DEPTH = LEVELS * THREADS;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int PROD_W     = 8 + $clog2(LEVELS + 1);
  localparam int SLICE_MAX  = 1023;

  localparam logic [7:0]  BASE_QUANTUM_RST = 8'd25;
  localparam logic [15:0] MAINT_PERIOD_RST = 16'd1000;
  localparam logic [15:0] STARVE_LIMIT_RST = 16'd200;

  localparam logic [1:0] REQ_ADMIT = 2'd0;
  localparam logic [1:0] REQ_SCHED = 2'd1;
  localparam logic [1:0] REQ_WAKE  = 2'd2;

  localparam logic [1:0] RUN_READY = 2'd0;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [1:0] CFG_BASE_QUANTUM = 2'd0;
  localparam logic [1:0] CFG_MAINT_PERIOD = 2'd1;
  localparam logic [1:0] CFG_STARVE_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [4:0]  thread_id;
    logic [1:0]  run_state;
    logic [15:0] run_ms;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [4:0] next_thread;
    logic       next_valid;
    logic [9:0] time_slice;
    logic [1:0] status;
  } rsp_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [15:0]      used;
    logic [31:0]      last;
  } thr_t;

  localparam int THR_W = $bits(thr_t);

endpackage

@@ rtl/core/mlfq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mlfq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/mlfq_thread_scheduler.sv @@
// Top level of the MLFQ thread scheduler: request sequencer, queue pointers
// and the two state memories. Depends on mlfq_pkg and mlfq_ram.
//
// One request is handled at a time. An admit or wake passes through S_LOOK
// to S_OUT. A schedule request passes through S_LOOK, S_CHARGE, S_REQUEUE,
// S_SEL, S_POP and S_OUT, skipping S_POP when every queue is empty, with an
// aging pass after S_CHARGE when it runs; the aging pass visits every thread
// in the lowest queue, reading slot memory and thread table for each.
// A finished result waits in an output register while the next request
// is accepted. Thread state lives in a 32-entry thread table with per-entry
// valid bits; queue contents live in a 128-entry slot memory.
module mlfq_thread_scheduler (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlfq_pkg::req_t     in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mlfq_pkg::rsp_t     out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data
);

  localparam logic [mlfq_pkg::LVL_W-1:0] LOW = mlfq_pkg::LVL_W'(mlfq_pkg::LEVELS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOOK, S_CHARGE, S_AGE_POP, S_AGE_SLOT, S_AGE_CHK,
    S_REQUEUE, S_SEL, S_POP, S_OUT
  } state_t;

  state_t state;
  mlfq_pkg::req_t req;
  mlfq_pkg::rsp_t result;
  mlfq_pkg::thr_t ent;
  logic [7:0]  base_quantum;
  logic [15:0] maint_period;
  logic [15:0] starve_limit;
  logic [mlfq_pkg::TID_W-1:0] q_head  [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::CNT_W-1:0] q_count [mlfq_pkg::LEVELS];
  logic [mlfq_pkg::THREADS-1:0] queued;
  logic [mlfq_pkg::THREADS-1:0] tvalid;
  logic [mlfq_pkg::TID_W-1:0] running;
  logic running_valid;
  logic [15:0] since;
  logic [15:0] used_new;
  logic [mlfq_pkg::PROD_W-1:0] qprod;
  logic [mlfq_pkg::CNT_W-1:0] age_n;
  logic [mlfq_pkg::CNT_W-1:0] age_k;
  logic [mlfq_pkg::TID_W-1:0] age_tid;
  logic rd_tv;

  logic t_we;
  logic [mlfq_pkg::TID_W-1:0] t_waddr;
  logic [mlfq_pkg::TID_W-1:0] t_raddr;
  mlfq_pkg::thr_t t_wdata;
  logic [mlfq_pkg::THR_W-1:0] t_rdata;
  mlfq_pkg::thr_t t_ent;

  logic push_en;
  logic [mlfq_pkg::LVL_W-1:0] push_q;
  logic [mlfq_pkg::TID_W-1:0] push_tid;
  logic pop_en;
  logic [mlfq_pkg::LVL_W-1:0] pop_q;
  logic [mlfq_pkg::CNT_W-1:0] tail_sum;
  logic [mlfq_pkg::TID_W-1:0] tail;
  logic [mlfq_pkg::SLOT_AW-1:0] s_waddr;
  logic [mlfq_pkg::SLOT_AW-1:0] s_raddr;
  logic [mlfq_pkg::TID_W-1:0] s_rdata;

  logic req_ok;
  logic demote;
  logic [mlfq_pkg::LVL_W-1:0] level_new;
  logic [16:0] msum;
  logic [16:0] used_sum;
  logic [mlfq_pkg::LVL_W:0] lvl_inc;
  logic [mlfq_pkg::LVL_W:0] sel_inc;
  logic starve;
  logic found;
  logic [mlfq_pkg::LVL_W-1:0] sel_q;

  mlfq_ram #(.WIDTH(mlfq_pkg::THR_W), .DEPTH(mlfq_pkg::THREADS)) u_thr_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  mlfq_ram #(.WIDTH(mlfq_pkg::TID_W), .DEPTH(mlfq_pkg::SLOT_DEPTH)) u_slot_ram (
    .clk(clk), .we(push_en), .waddr(s_waddr), .wdata(push_tid),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign t_ent    = rd_tv ? mlfq_pkg::thr_t'(t_rdata) : '0;
  assign req_ok   = (int'(req.thread_id) < mlfq_pkg::THREADS) &&
                    !queued[req.thread_id[mlfq_pkg::TID_W-1:0]] &&
                    !(running_valid && (running == req.thread_id[mlfq_pkg::TID_W-1:0]));
  assign used_sum = {1'b0, t_ent.used} + {1'b0, req.run_ms};
  assign lvl_inc  = {1'b0, t_ent.level} + (mlfq_pkg::LVL_W + 1)'(1);
  assign demote   = (req.run_state == mlfq_pkg::RUN_READY) &&
                    ({{(16 - mlfq_pkg::PROD_W){1'b0}}, qprod} <= used_new) &&
                    (ent.level != LOW);
  assign level_new = demote ? ent.level + mlfq_pkg::LVL_W'(1) : ent.level;
  assign msum     = {1'b0, since} + 17'(qprod);
  assign starve   = (req.now_ms - t_ent.last) >= {16'b0, starve_limit};
  assign tail_sum = mlfq_pkg::CNT_W'(q_head[push_q]) + q_count[push_q];
  assign tail     = (int'(tail_sum) >= mlfq_pkg::THREADS) ?
                    mlfq_pkg::TID_W'(tail_sum - mlfq_pkg::CNT_W'(mlfq_pkg::THREADS)) :
                    mlfq_pkg::TID_W'(tail_sum);
  assign s_waddr  = mlfq_pkg::SLOT_AW'(push_q) * mlfq_pkg::SLOT_AW'(mlfq_pkg::THREADS) +
                    mlfq_pkg::SLOT_AW'(tail);
  assign s_raddr  = mlfq_pkg::SLOT_AW'(pop_q) * mlfq_pkg::SLOT_AW'(mlfq_pkg::THREADS) +
                    mlfq_pkg::SLOT_AW'(q_head[pop_q]);

  always_comb begin
    found = 1'b0;
    sel_q = '0;
    for (int q = mlfq_pkg::LEVELS - 1; q >= 0; q--) begin
      if (q_count[q] != '0) begin
        found = 1'b1;
        sel_q = mlfq_pkg::LVL_W'(q);
      end
    end
  end
  assign sel_inc = {1'b0, sel_q} + (mlfq_pkg::LVL_W + 1)'(1);

  always_comb begin
    t_we     = 1'b0;
    t_waddr  = running;
    t_wdata  = '0;
    t_raddr  = running;
    push_en  = 1'b0;
    push_q   = '0;
    push_tid = '0;
    pop_en   = 1'b0;
    pop_q    = LOW;
    case (state)
      S_IDLE: begin
        if (in_data.req_type != mlfq_pkg::REQ_SCHED) begin
          t_raddr = in_data.thread_id[mlfq_pkg::TID_W-1:0];
        end
      end
      S_LOOK: begin
        if (req_ok && req.req_type == mlfq_pkg::REQ_ADMIT) begin
          t_we     = 1'b1;
          t_waddr  = req.thread_id[mlfq_pkg::TID_W-1:0];
          t_wdata  = '{level: '0, used: '0, last: req.now_ms};
          push_en  = 1'b1;
          push_tid = req.thread_id[mlfq_pkg::TID_W-1:0];
        end else if (req_ok && req.req_type == mlfq_pkg::REQ_WAKE) begin
          push_en  = 1'b1;
          push_q   = t_ent.level;
          push_tid = req.thread_id[mlfq_pkg::TID_W-1:0];
        end
      end
      S_CHARGE: begin
        if (running_valid) begin
          t_we    = 1'b1;
          t_wdata = '{level: level_new, used: demote ? 16'd0 : used_new, last: req.now_ms};
        end
      end
      S_AGE_POP: begin
        pop_en = (age_k != age_n);
      end
      S_AGE_SLOT: begin
        t_raddr = s_rdata;
      end
      S_AGE_CHK: begin
        push_en  = 1'b1;
        push_tid = age_tid;
        push_q   = starve ? '0 : LOW;
        if (starve) begin
          t_we    = 1'b1;
          t_waddr = age_tid;
          t_wdata = '{level: '0, used: t_ent.used, last: t_ent.last};
        end
      end
      S_REQUEUE: begin
        if (running_valid && req.run_state == mlfq_pkg::RUN_READY) begin
          push_en  = 1'b1;
          push_q   = ent.level;
          push_tid = running;
        end
      end
      S_SEL: begin
        pop_en = found;
        pop_q  = sel_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      base_quantum  <= mlfq_pkg::BASE_QUANTUM_RST;
      maint_period  <= mlfq_pkg::MAINT_PERIOD_RST;
      starve_limit  <= mlfq_pkg::STARVE_LIMIT_RST;
      q_head        <= '{default: '0};
      q_count       <= '{default: '0};
      queued        <= '0;
      tvalid        <= '0;
      running       <= '0;
      running_valid <= 1'b1;
      since         <= '0;
      out_valid     <= 1'b0;
      rd_tv         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          mlfq_pkg::CFG_BASE_QUANTUM: base_quantum <= cfg_data[7:0];
          mlfq_pkg::CFG_MAINT_PERIOD: maint_period <= cfg_data;
          mlfq_pkg::CFG_STARVE_LIMIT: starve_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      if (t_we) begin
        tvalid[t_waddr] <= 1'b1;
      end
      rd_tv <= tvalid[t_raddr];
      if (push_en) begin
        queued[push_tid] <= 1'b1;
        q_count[push_q]  <= q_count[push_q] + mlfq_pkg::CNT_W'(1);
      end
      if (pop_en) begin
        q_head[pop_q]  <= (int'(q_head[pop_q]) == mlfq_pkg::THREADS - 1) ? '0 :
                          q_head[pop_q] + mlfq_pkg::TID_W'(1);
        q_count[pop_q] <= q_count[pop_q] - mlfq_pkg::CNT_W'(1);
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req   <= in_data;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (req.req_type == mlfq_pkg::REQ_SCHED) begin
            result   <= '0;
            ent      <= t_ent;
            used_new <= used_sum[16] ? 16'hFFFF : used_sum[15:0];
            qprod    <= mlfq_pkg::PROD_W'(base_quantum) * mlfq_pkg::PROD_W'(lvl_inc);
            state    <= S_CHARGE;
          end else begin
            if (req_ok && (req.req_type == mlfq_pkg::REQ_ADMIT ||
                           req.req_type == mlfq_pkg::REQ_WAKE)) begin
              result <= '0;
            end else begin
              result <= '{next_thread: '0, next_valid: 1'b0, time_slice: '0,
                          status: mlfq_pkg::ST_INVALID};
            end
            state <= S_OUT;
          end
        end
        S_CHARGE: begin
          ent.level <= level_new;
          if (msum >= {1'b0, maint_period}) begin
            since <= '0;
            age_n <= q_count[LOW];
            age_k <= '0;
            state <= S_AGE_POP;
          end else begin
            since <= msum[15:0];
            state <= S_REQUEUE;
          end
        end
        S_AGE_POP: begin
          state <= (age_k == age_n) ? S_REQUEUE : S_AGE_SLOT;
        end
        S_AGE_SLOT: begin
          age_tid <= s_rdata;
          state   <= S_AGE_CHK;
        end
        S_AGE_CHK: begin
          age_k <= age_k + mlfq_pkg::CNT_W'(1);
          state <= S_AGE_POP;
        end
        S_REQUEUE: begin
          state <= S_SEL;
        end
        S_SEL: begin
          if (!found) begin
            running_valid <= 1'b0;
            result.status <= mlfq_pkg::ST_EMPTY;
            state         <= S_OUT;
          end else begin
            qprod <= mlfq_pkg::PROD_W'(base_quantum) * mlfq_pkg::PROD_W'(sel_inc);
            state <= S_POP;
          end
        end
        S_POP: begin
          running            <= s_rdata;
          running_valid      <= 1'b1;
          queued[s_rdata]    <= 1'b0;
          result.next_thread <= 5'(s_rdata);
          result.next_valid  <= 1'b1;
          result.time_slice  <= (int'(qprod) > mlfq_pkg::SLICE_MAX) ? 10'h3FF : qprod[9:0];
          result.status      <= mlfq_pkg::ST_OK;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_data  <= result;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/mlfq_checker.sv @@
// Port-level checker for the MLFQ thread scheduler and its bind statement.
// Depends on mlfq_pkg and mlfq_thread_scheduler_defines.svh.
`include "mlfq_thread_scheduler_defines.svh"

module mlfq_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_ready,
  input mlfq_pkg::req_t in_data,
  input logic           out_valid,
  input logic           out_ready,
  input mlfq_pkg::rsp_t out_data,
  input logic           cfg_we,
  input logic [1:0]     cfg_addr,
  input logic [15:0]    cfg_data
);

  `MLFQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")
  `MLFQ_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request taken while busy")
  `MLFQ_ASSERT_IMPL(a_dispatch_ok, out_valid && out_data.next_valid, out_data.status == mlfq_pkg::ST_OK, "dispatch with error status")
  `MLFQ_ASSERT_IMPL(a_no_dispatch_zero, out_valid && !out_data.next_valid, out_data.next_thread == 5'd0 && out_data.time_slice == 10'd0, "idle result carries data")

endmodule

bind mlfq_thread_scheduler mlfq_checker u_mlfq_checker (.*);
